// ===== rtl/core/rpc_pkg.sv =====
// rpc_pkg: constants, types and helper functions of the rectangular/polar converter
// shared by the cordic cells, the entry and exit stages and the top level
// no dependencies
package rpc_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 8;

    localparam int TABLE_LEN  = 24;
    localparam int TABLE_FRAC = 12;

    // guard bits and number of rotation steps, limited to what the table supports
    localparam int GUARD = (FRACTION_BITS > TABLE_FRAC) ? TABLE_FRAC : FRACTION_BITS;
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SHW   = $clog2(STEPS);

    // working widths: vector, angle accumulator, rounded angle
    localparam int VW = 19 + GUARD;
    localparam int ZW = 18 + GUARD;
    localparam int AW = 18;

    // gain removal: multiply by INV_GAIN, then round off GAIN_SHIFT + GUARD bits
    localparam int INV_GAIN   = 10188014;
    localparam int GAIN_SHIFT = 24;
    localparam int KW         = 25;
    localparam int PW         = VW + KW;
    localparam int MSH        = GAIN_SHIFT + GUARD;
    localparam int MW         = PW - MSH;

    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int FULL_TURN    = 46080;
    localparam int MAG_LIMIT    = 65535;

    localparam logic signed [AW-1:0] HALF_A    = AW'(HALF_TURN);
    localparam logic signed [AW-1:0] QUARTER_A = AW'(QUARTER_TURN);
    localparam logic signed [AW-1:0] FULL_A    = AW'(FULL_TURN);
    localparam logic signed [ZW-1:0] HALF_Z    = ZW'(longint'(HALF_TURN) << GUARD);
    localparam logic signed [ZW-1:0] ANG_HALF  = ZW'((1 << GUARD) >> 1);
    localparam logic signed [KW-1:0] INV_K     = KW'(INV_GAIN);
    localparam logic signed [PW-1:0] MUL_HALF  = PW'(longint'(1) << (MSH - 1));
    localparam logic signed [MW-1:0] MAG_MAX   = MW'(MAG_LIMIT);
    localparam logic signed [MW-1:0] S16_MAX   = MW'(32767);
    localparam logic signed [MW-1:0] S16_MIN   = -MW'(32768);

    // atan(2^-i) in 1/524288 degree
    localparam int ATAN_TBL [TABLE_LEN] = '{
        23592960, 13927738, 7359034, 3735561, 1875029, 938429, 469329, 234679,
        117341, 58671, 29335, 14668, 7334, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4
    };

    typedef enum logic [1:0] {
        CMD_RECT  = 2'd0,
        CMD_POLAR = 2'd1
    } t_cmd;

    typedef struct packed {
        logic               polar;
        logic               bad;
        logic               zero;
        logic signed [15:0] op_a;
        logic signed [15:0] op_b;
        logic signed [15:0] ang_w;
    } t_meta;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    typedef struct packed {
        t_meta meta;
        t_vec  vec;
    } t_stage;

    // step angle rounded half up to the guard precision
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        int sh;
        sh = TABLE_FRAC - GUARD;
        return ZW'((ATAN_TBL[i] + ((1 << sh) >> 1)) >>> sh);
    endfunction

    // fold an angle into (-half turn, half turn]
    function automatic logic signed [AW-1:0] wrap_angle(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        r = a;
        if (r > HALF_A) begin
            r = r - FULL_A;
        end
        if (r <= -HALF_A) begin
            r = r + FULL_A;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [MW-1:0] v);
        logic signed [15:0] r;
        if (v > S16_MAX) begin
            r = 16'sh7fff;
        end else if (v < S16_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rpc_in_if.sv =====
// rpc_in_if: input channel of the converter, valid/ready with command and two operands
// no dependencies
interface rpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] operand_a;
    logic signed [15:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

// ===== rtl/core/rpc_out_if.sv =====
// rpc_out_if: result channel of the converter, valid/ready with coordinates and flags
// no dependencies
interface rpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [16:0] magnitude;
    logic signed [15:0] angle;
    logic               is_polar;
    logic               bad_mode;

    modport source (output valid, x_coord, y_coord, magnitude, angle, is_polar, bad_mode,
                    input ready);
    modport sink   (input valid, x_coord, y_coord, magnitude, angle, is_polar, bad_mode,
                    output ready);
endinterface

// ===== rtl/core/rpc_prep.sv =====
// rpc_prep: entry stage, decodes the command and sets up the start vector of the cordic chain
// depends on rpc_pkg and rpc_in_if
module rpc_prep import rpc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rpc_in_if.sink i_in,
    output logic   o_valid,
    input  logic   i_ready,
    output t_stage o_data
);

    logic                 r_valid;
    t_stage               r_data;
    t_stage               n_data;
    logic                 w_take;
    logic signed [VW-1:0] w_a_v;
    logic signed [VW-1:0] w_b_v;
    logic signed [AW-1:0] w_b_w;
    logic signed [AW-1:0] w_a_f;
    logic signed [16:0]   w_m;

    assign i_in.ready = !r_valid || i_ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        w_a_v = VW'(i_in.operand_a) <<< GUARD;
        w_b_v = VW'(i_in.operand_b) <<< GUARD;
        w_b_w = wrap_angle(AW'(i_in.operand_b));
        w_a_f = w_b_w;
        w_m   = 17'(i_in.operand_a);

        n_data           = '0;
        n_data.meta.op_a = i_in.operand_a;
        n_data.meta.op_b = i_in.operand_b;
        n_data.meta.zero = (i_in.operand_a == 16'sd0) && (i_in.operand_b == 16'sd0);

        case (i_in.cmd)
            CMD_RECT: begin
                // left half plane: turn by a half turn first
                if (i_in.operand_a < 16'sd0) begin
                    n_data.vec.x = -w_a_v;
                    n_data.vec.y = -w_b_v;
                    n_data.vec.z = (i_in.operand_b >= 16'sd0) ? HALF_Z : -HALF_Z;
                end else begin
                    n_data.vec.x = w_a_v;
                    n_data.vec.y = w_b_v;
                end
            end
            CMD_POLAR: begin
                n_data.meta.polar = 1'b1;
                n_data.meta.ang_w = w_b_w[15:0];
                if (w_b_w > QUARTER_A) begin
                    w_a_f = w_b_w - HALF_A;
                    w_m   = -w_m;
                end else if (w_b_w < -QUARTER_A) begin
                    w_a_f = w_b_w + HALF_A;
                    w_m   = -w_m;
                end
                n_data.vec.x = VW'(w_m) <<< GUARD;
                n_data.vec.z = ZW'(w_a_f) <<< GUARD;
            end
            default: begin
                n_data.meta.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rpc_cell.sv =====
// rpc_cell: one cordic micro-rotation with its own pipeline register
// depends on rpc_pkg
module rpc_cell import rpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SHW-1:0]       i_shift,
    input  logic signed [ZW-1:0] i_atan,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_stage               i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_stage               o_data
);

    logic                 r_valid;
    t_stage               r_data;
    t_stage               n_data;
    logic signed [VW-1:0] w_dx;
    logic signed [VW-1:0] w_dy;
    logic                 w_cw;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_dx = i_data.vec.y >>> i_shift;
        w_dy = i_data.vec.x >>> i_shift;
        // vectoring drives y to zero, rotation drives z to zero
        w_cw = i_data.meta.polar ? (i_data.vec.z < 0) : (i_data.vec.y >= 0);
        n_data = i_data;
        if (w_cw) begin
            n_data.vec.x = i_data.vec.x + w_dx;
            n_data.vec.y = i_data.vec.y - w_dy;
            n_data.vec.z = i_data.vec.z + i_atan;
        end else begin
            n_data.vec.x = i_data.vec.x - w_dx;
            n_data.vec.y = i_data.vec.y + w_dy;
            n_data.vec.z = i_data.vec.z - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rpc_post.sv =====
// rpc_post: exit stages, gain removal by multiplication, rounding, saturation and result select
// depends on rpc_pkg and rpc_out_if
module rpc_post import rpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_stage    i_data,
    rpc_out_if.source o_out
);

    // multiply stage
    logic                 r_a_valid;
    t_meta                r_a_meta;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [AW-1:0] r_ang;
    logic signed [PW-1:0] n_px;
    logic signed [PW-1:0] n_py;
    logic signed [ZW-1:0] w_zr;
    logic                 w_a_ready;

    // output stage
    logic                 r_b_valid;
    logic signed [15:0]   r_x;
    logic signed [15:0]   r_y;
    logic signed [16:0]   r_mag;
    logic signed [15:0]   r_ang_o;
    logic                 r_polar;
    logic                 r_bad;
    logic signed [15:0]   n_x;
    logic signed [15:0]   n_y;
    logic signed [16:0]   n_mag;
    logic signed [15:0]   n_ang;
    logic signed [PW-1:0] w_rx;
    logic signed [PW-1:0] w_ry;
    logic signed [MW-1:0] w_mx;
    logic signed [MW-1:0] w_my;
    logic signed [AW-1:0] w_aw;
    logic                 w_b_ready;

    assign w_b_ready = !r_b_valid || o_out.ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    always_comb begin
        n_px = PW'(i_data.vec.x) * PW'(INV_K);
        n_py = PW'(i_data.vec.y) * PW'(INV_K);
        w_zr = (i_data.vec.z + ANG_HALF) >>> GUARD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_a_ready) begin
            r_a_meta <= i_data.meta;
            r_px     <= n_px;
            r_py     <= n_py;
            r_ang    <= w_zr[AW-1:0];
        end
    end

    always_comb begin
        w_rx = (r_px + MUL_HALF) >>> MSH;
        w_ry = (r_py + MUL_HALF) >>> MSH;
        w_mx = w_rx[MW-1:0];
        w_my = w_ry[MW-1:0];
        w_aw = wrap_angle(r_ang);
        n_x   = '0;
        n_y   = '0;
        n_mag = '0;
        n_ang = '0;
        if (r_a_meta.bad) begin
            // unknown command: zero vector
        end else if (r_a_meta.polar) begin
            n_x   = sat16(w_mx);
            n_y   = sat16(w_my);
            n_mag = 17'(r_a_meta.op_a);
            n_ang = r_a_meta.ang_w;
        end else begin
            n_x = r_a_meta.op_a;
            n_y = r_a_meta.op_b;
            if (!r_a_meta.zero) begin
                n_mag = (w_mx > MAG_MAX) ? MAG_MAX[16:0] : w_mx[16:0];
                n_ang = w_aw[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && w_b_ready) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_mag   <= n_mag;
            r_ang_o <= n_ang;
            r_polar <= r_a_meta.polar;
            r_bad   <= r_a_meta.bad;
        end
    end

    assign o_out.valid     = r_b_valid;
    assign o_out.x_coord   = r_x;
    assign o_out.y_coord   = r_y;
    assign o_out.magnitude = r_mag;
    assign o_out.angle     = r_ang_o;
    assign o_out.is_polar  = r_polar;
    assign o_out.bad_mode  = r_bad;

endmodule

// ===== rtl/core/rect_polar_converter.sv =====
// rect_polar_converter: pipelined cordic converter between rectangular and polar form
// depends on rpc_pkg, rpc_in_if, rpc_out_if, rpc_prep, rpc_cell and rpc_post
//
// usage
// - i_in carries one beat per conversion: cmd (rectangular or polar), operand_a, operand_b
// - o_out carries one beat per input beat, in order: x, y, magnitude, angle, mode flags
// - rectangular beats give length and direction, polar beats give x and y
// - an unknown cmd gives an all-zero vector with bad_mode set
// - coordinates are signed q8.8, angles count 1/128 degree in (-180, 180]
// structure and throughput
// - an accepted beat passes one entry stage, one cell per cordic step (16),
//   one multiply stage for gain removal and one output register to its result
// - one beat per cycle while o_out.ready holds; each stage holds at most one beat
// stalls and reset
// - each stage takes a new beat when it is empty or its successor takes its beat, so a
//   stalled receiver only fills the bubbles; i_in.ready drops once the chain is full
// - synchronous active-low reset empties every stage; stalls lose or repeat no result
module rect_polar_converter import rpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpc_in_if.sink    i_in,
    rpc_out_if.source o_out
);

    // handshake and data between neighbouring stages, index k feeds cell k
    t_stage w_data  [STEPS+1];
    logic   w_valid [STEPS+1];
    logic   w_ready [STEPS+1];

    // entry: command decode and start vector
    rpc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // row of micro-rotation cells, each with a fixed shift and step angle
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        rpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHW'(k)),
            .i_atan  (atan_step(k)),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // exit: gain removal, rounding and the output register
    rpc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STEPS]),
        .o_ready (w_ready[STEPS]),
        .i_data  (w_data[STEPS]),
        .o_out   (o_out)
    );

endmodule
